>>> rtl/text_to_integer_radix_macros.svh
// Assertion macros used by the text_to_integer_radix top level.
// Stand-alone header; include it with the bare file name.
`ifndef TEXT_TO_INTEGER_RADIX_MACROS_SVH
`define TEXT_TO_INTEGER_RADIX_MACROS_SVH

// same-cycle implication, disabled while reset is high
`define TTIR_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled while reset is high
`define TTIR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/ttir_pkg.sv
// Types, constants and character classification for text_to_integer_radix.
// No dependencies; used by every module of the block.
package ttir_pkg;

   localparam int CH_W     = 8;
   localparam int VALUE_W  = 64;
   localparam int OFFSET_W = 16;
   localparam int RADIX_W  = 6;

   localparam logic [RADIX_W-1:0] NO_DIGIT = 6'd63;
   localparam logic [RADIX_W-1:0] BASE_DEC = 6'd10;
   localparam logic [RADIX_W-1:0] BASE_HEX = 6'd16;
   localparam logic [RADIX_W-1:0] BASE_OCT = 6'd8;
   localparam logic [RADIX_W-1:0] BASE_MAX = 6'd36;
   localparam logic [RADIX_W-1:0] RADIX_AUTO_MAX = 6'd1;

   localparam logic [CH_W-1:0] CH_NUL   = 8'h00;
   localparam logic [CH_W-1:0] CH_SPACE = 8'h20;
   localparam logic [CH_W-1:0] CH_MINUS = 8'h2D;
   localparam logic [CH_W-1:0] CH_PLUS  = 8'h2B;
   localparam logic [CH_W-1:0] CH_ZERO  = 8'h30;
   localparam logic [CH_W-1:0] CH_NINE  = 8'h39;
   localparam logic [CH_W-1:0] CH_UP_A  = 8'h41;
   localparam logic [CH_W-1:0] CH_UP_Z  = 8'h5A;
   localparam logic [CH_W-1:0] CH_LO_A  = 8'h61;
   localparam logic [CH_W-1:0] CH_LO_Z  = 8'h7A;
   localparam logic [CH_W-1:0] CH_X     = 8'h78;
   localparam logic [CH_W-1:0] CH_TAB   = 8'h09;
   localparam logic [CH_W-1:0] CH_CR    = 8'h0D;

   // offset saturation point
   localparam logic [OFFSET_W-1:0] OFFSET_CAP = 16'hFFFF;

   // one classified character
   typedef struct packed {
      logic                first;
      logic                is_nul;
      logic                is_space;
      logic                is_minus;
      logic                is_plus;
      logic                is_zero;
      logic                is_x;
      logic [RADIX_W-1:0]  digit;   // NO_DIGIT when not alphanumeric
   } ttir_item_type;

   typedef enum logic [6:0] {
      PH_IDLE     = 7'b0000001,
      PH_SPACE    = 7'b0000010,
      PH_SIGNED   = 7'b0000100,
      PH_ZERO     = 7'b0001000,
      PH_PREFIXED = 7'b0010000,
      PH_DIGITS   = 7'b0100000,
      PH_DONE     = 7'b1000000
   } ttir_phase_type;

   function automatic logic [RADIX_W-1:0] digit_of(input logic [CH_W-1:0] c);
      logic [CH_W-1:0] d;
      d = '0;
      if (c inside {[CH_ZERO:CH_NINE]}) begin
         d = c - CH_ZERO;
      end else if (c inside {[CH_UP_A:CH_UP_Z]}) begin
         d = c - CH_UP_A + 8'd10;
      end else if (c inside {[CH_LO_A:CH_LO_Z]}) begin
         d = c - CH_LO_A + 8'd10;
      end else begin
         d = {2'b00, NO_DIGIT};
      end
      return d[RADIX_W-1:0];
   endfunction

   function automatic ttir_item_type classify(input logic [CH_W-1:0] c, input logic f);
      ttir_item_type it;
      it.first    = f;
      it.is_nul   = (c == CH_NUL);
      it.is_space = (c == CH_SPACE) || (c inside {[CH_TAB:CH_CR]});
      it.is_minus = (c == CH_MINUS);
      it.is_plus  = (c == CH_PLUS);
      it.is_zero  = (c == CH_ZERO);
      it.is_x     = (c == CH_X);
      it.digit    = digit_of(c);
      return it;
   endfunction

endpackage

>>> rtl/ttir_front.sv
// Front stage: takes input items and registers their classified form.
// Depends on ttir_pkg.
module ttir_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic [ttir_pkg::CH_W-1:0]     in_ch,
   input  logic                          in_first,
   output logic                          item_valid,
   input  logic                          item_ready,
   output ttir_pkg::ttir_item_type       item
);
   import ttir_pkg::*;

   logic          valid_ff, valid_in;
   ttir_item_type item_ff;

   assign in_ready   = !valid_ff || item_ready;
   assign valid_in   = (in_valid && in_ready) || (valid_ff && !item_ready);
   assign item_valid = valid_ff;
   assign item       = item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         item_ff <= classify(in_ch, in_first);
      end
   end

endmodule

>>> rtl/ttir_queue.sv
// Short FIFO of classified items between front and back.
// Depends on ttir_pkg.
module ttir_queue #(
   parameter int DEPTH = 4
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                push_valid,
   output logic                                push_ready,
   input  ttir_pkg::ttir_item_type             push_item,
   output logic                                pop_valid,
   input  logic                                pop_ready,
   output ttir_pkg::ttir_item_type             pop_item,
   output logic [$clog2(DEPTH+1)-1:0]          level
);
   import ttir_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int LVL_W = $clog2(DEPTH+1);
   localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

   ttir_item_type    mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [LVL_W-1:0] level_ff, level_in;
   logic             push, pop;

   assign push_ready = (level_ff != LVL_W'(DEPTH));
   assign pop_valid  = (level_ff != '0);
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_item   = mem_ff[rd_ptr_ff];
   assign level      = level_ff;

   always_comb begin
      wr_ptr_in = push ? ((wr_ptr_ff == LAST) ? '0 : wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = pop  ? ((rd_ptr_ff == LAST) ? '0 : rd_ptr_ff + 1'b1) : rd_ptr_ff;
      level_in  = level_ff;
      if (push && !pop) begin
         level_in = level_ff + 1'b1;
      end else if (pop && !push) begin
         level_in = level_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

>>> rtl/ttir_back.sv
// Back stage: parser state machine, digit accumulator and result register.
// Depends on ttir_pkg.
module ttir_back (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [ttir_pkg::RADIX_W-1:0]    radix,
   input  logic                            item_valid,
   output logic                            item_ready,
   input  ttir_pkg::ttir_item_type         item,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [ttir_pkg::VALUE_W-1:0]    rsp_value,
   output logic [ttir_pkg::OFFSET_W-1:0]   rsp_offset,
   output logic                            rsp_end_valid
);
   import ttir_pkg::*;

   ttir_phase_type      phase_ff, phase_in, phase_cur;
   logic                neg_ff, neg_in, neg_cur;
   logic [RADIX_W-1:0]  base_ff, base_in, base_cur, radix_base;
   logic [VALUE_W-1:0]  acc_ff, acc_in, acc_cur;
   logic [OFFSET_W-1:0] idx_ff, idx_in, idx_cur;
   logic [VALUE_W+RADIX_W-1:0] prod;
   logic                pop, active, after_sign, step_prefix, step_digit;
   logic                take, emit_nul, emit_val;

   logic                rsp_valid_ff, rsp_valid_in, end_valid_ff;
   logic [VALUE_W-1:0]  value_ff;
   logic [OFFSET_W-1:0] offset_ff;

   assign item_ready = !rsp_valid_ff || rsp_ready;
   assign pop        = item_valid && item_ready;

   // a start marker restarts the parser on this very character
   assign phase_cur = item.first ? PH_SPACE : phase_ff;
   assign neg_cur   = item.first ? 1'b0 : neg_ff;
   assign base_cur  = item.first ? BASE_DEC : base_ff;
   assign acc_cur   = item.first ? '0 : acc_ff;
   assign idx_cur   = item.first ? '0 : idx_ff;
   assign active    = (phase_cur != PH_IDLE) && (phase_cur != PH_DONE);

   always_comb begin
      if (radix <= RADIX_AUTO_MAX) begin
         radix_base = BASE_DEC;
      end else if (radix > BASE_MAX) begin
         radix_base = BASE_MAX;
      end else begin
         radix_base = radix;
      end
   end

   always_comb begin
      phase_in    = phase_cur;
      neg_in      = neg_cur;
      base_in     = base_cur;
      after_sign  = 1'b0;
      step_prefix = 1'b0;
      step_digit  = 1'b0;
      take        = 1'b0;
      emit_nul    = 1'b0;
      emit_val    = 1'b0;
      case (phase_cur)
         PH_SPACE: begin
            if (item.is_space) begin
               phase_in = PH_SPACE;
            end else if (item.is_minus) begin
               neg_in   = 1'b1;
               phase_in = PH_SIGNED;
            end else if (item.is_plus) begin
               phase_in = PH_SIGNED;
            end else begin
               after_sign = 1'b1;
            end
         end
         PH_SIGNED: begin
            after_sign = 1'b1;
         end
         PH_ZERO: begin
            if (item.is_x) begin
               base_in  = BASE_HEX;
               phase_in = PH_PREFIXED;
            end else begin
               base_in     = BASE_OCT;
               step_prefix = 1'b1;
            end
         end
         PH_PREFIXED: begin
            step_prefix = 1'b1;
         end
         PH_DIGITS: begin
            step_digit = 1'b1;
         end
         default: begin
            phase_in = phase_cur;
         end
      endcase
      // leading zero defers the base choice to the next character
      if (after_sign) begin
         if (item.is_zero) begin
            phase_in = PH_ZERO;
         end else begin
            base_in     = radix_base;
            step_prefix = 1'b1;
         end
      end
      if (step_prefix) begin
         if (item.is_nul) begin
            emit_nul = 1'b1;
         end else begin
            step_digit = 1'b1;
         end
      end
      if (step_digit) begin
         if (item.digit < base_in) begin
            take     = 1'b1;
            phase_in = PH_DIGITS;
         end else begin
            emit_val = 1'b1;
         end
      end
      if (emit_nul || emit_val) begin
         phase_in = PH_DONE;
      end
   end

   // one multiply by a base of at most 36, then add the digit; wraps mod 2^64
   assign prod   = acc_cur * base_in;
   assign acc_in = take ? (prod[VALUE_W-1:0] + VALUE_W'(item.digit)) : acc_cur;

   always_comb begin
      idx_in = idx_cur;
      if (active && (idx_cur < OFFSET_CAP)) begin
         idx_in = idx_cur + 1'b1;
      end
   end

   assign rsp_valid_in = (pop && (emit_nul || emit_val)) || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         neg_ff       <= 1'b0;
         base_ff      <= BASE_DEC;
         acc_ff       <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (pop) begin
            phase_ff <= phase_in;
            neg_ff   <= neg_in;
            base_ff  <= base_in;
            acc_ff   <= acc_in;
            idx_ff   <= idx_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop && emit_nul) begin
         value_ff     <= '0;
         offset_ff    <= '0;
         end_valid_ff <= 1'b0;
      end else if (pop && emit_val) begin
         value_ff     <= neg_cur ? (VALUE_W'(0) - acc_cur) : acc_cur;
         offset_ff    <= idx_cur;
         end_valid_ff <= 1'b1;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_value     = value_ff;
   assign rsp_offset    = offset_ff;
   assign rsp_end_valid = end_valid_ff;

endmodule

>>> rtl/text_to_integer_radix.sv
// Top level of the streaming text-to-integer parser.
// Depends on ttir_pkg, ttir_front, ttir_queue, ttir_back and the macros header.
//
// Usage:
//  - req channel: one character per item, req_tdata = ch, req_tuser = first.
//    first = 1 starts a new string at that character; characters with
//    first = 0 outside a string are dropped without a result.
//  - rsp channel: one item per finished string: rsp_tdata[63:0] = value,
//    rsp_tdata[79:64] = end_offset, rsp_tuser = end_valid.
//  - csr channel: writes the radix register (0 or 1 = auto, 2..36 base,
//    above 36 acts as 36). csr_ready is always high; write only when idle.
//  - Throughput: one character per cycle, sustained while rsp_tready is high.
//  - Result path: the stopping character goes from the front register into a
//    queue entry and then into the result register; it waits in the queue while
//    the back stage stalls. The back stage's 64 x 6 multiply-add is the per-
//    character loop and sets the cycle budget.
//  - Reset clears the parser to idle, radix to auto and empties the queue.
//  - When a result waits with rsp_tready low the result register holds, the back
//    stage stops, the queue fills, and req_tready drops once front and queue are full.
`include "text_to_integer_radix_macros.svh"

module text_to_integer_radix #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // input characters
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [7:0]                           req_tdata,   // [7:0] ch
   input  logic                                 req_tuser,   // [0] first
   // results
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [79:0]                          rsp_tdata,   // [63:0] value, [79:64] end_offset
   output logic                                 rsp_tuser,   // [0] end_valid
   // radix register write
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [ttir_pkg::RADIX_W-1:0]         csr_data
);
   import ttir_pkg::*;

   localparam int LVL_W = $clog2(QUEUE_DEPTH+1);

   logic [RADIX_W-1:0]  radix_ff;
   logic                front_valid, front_ready, head_valid, head_ready;
   ttir_item_type       front_item, head_item;
   logic [LVL_W-1:0]    q_level;
   logic [VALUE_W-1:0]  rsp_value;
   logic [OFFSET_W-1:0] rsp_offset;

   // radix register
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         radix_ff <= csr_data;
      end
   end

   ttir_front u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_ch      (req_tdata),
      .in_first   (req_tuser),
      .item_valid (front_valid),
      .item_ready (front_ready),
      .item       (front_item)
   );

   ttir_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_ready (front_ready),
      .push_item  (front_item),
      .pop_valid  (head_valid),
      .pop_ready  (head_ready),
      .pop_item   (head_item),
      .level      (q_level)
   );

   ttir_back u_back (
      .clock         (clock),
      .reset         (reset),
      .radix         (radix_ff),
      .item_valid    (head_valid),
      .item_ready    (head_ready),
      .item          (head_item),
      .rsp_valid     (rsp_tvalid),
      .rsp_ready     (rsp_tready),
      .rsp_value     (rsp_value),
      .rsp_offset    (rsp_offset),
      .rsp_end_valid (rsp_tuser)
   );

   assign rsp_tdata = {rsp_offset, rsp_value};

   // early NUL return carries a zero value and a zero offset
   `TTIR_ASSERT_IMPL(a_nul_result_zero, clock, reset, rsp_tvalid && !rsp_tuser, rsp_tdata == '0, "early NUL result not zero")
   // an accepted character always lands in the front register
   `TTIR_ASSERT_NEXT(a_front_loaded, clock, reset, req_tvalid && req_tready, front_valid, "accepted item lost at front")
   // queue occupancy stays within its depth
   `TTIR_ASSERT_IMPL(a_queue_bound, clock, reset, 1'b1, q_level <= LVL_W'(QUEUE_DEPTH), "queue level above depth")

endmodule
